@@ design/pcmmix_pkg.sv @@
`timescale 1ns / 1ps

package pcmmix_pkg;

  // sample format codes of the format register
  localparam logic [3:0] FMT_U8    = 4'd0;
  localparam logic [3:0] FMT_S8    = 4'd1;
  localparam logic [3:0] FMT_U16LE = 4'd2;
  localparam logic [3:0] FMT_S16LE = 4'd3;
  localparam logic [3:0] FMT_U16BE = 4'd4;
  localparam logic [3:0] FMT_S16BE = 4'd5;
  localparam logic [3:0] FMT_U32LE = 4'd6;
  localparam logic [3:0] FMT_S32LE = 4'd7;
  localparam logic [3:0] FMT_U32BE = 4'd8;
  localparam logic [3:0] FMT_S32BE = 4'd9;

  typedef enum logic [1:0] {
    W8,
    W16,
    W32
  } width_t;

  // decoded format, travels with each word down the pipe
  typedef struct packed {
    logic   legal;
    width_t width;
    logic   is_signed;
    logic   big;
  } fmt_ctrl_t;

  function automatic fmt_ctrl_t decode_fmt(input logic [3:0] fmt);
    fmt_ctrl_t c;
    c.legal     = 1'b1;
    c.width     = W8;
    c.is_signed = 1'b0;
    c.big       = 1'b0;
    unique case (fmt)
      FMT_U8: begin
      end
      FMT_S8: begin
        c.is_signed = 1'b1;
      end
      FMT_U16LE: begin
        c.width = W16;
      end
      FMT_S16LE: begin
        c.width = W16;
        c.is_signed = 1'b1;
      end
      FMT_U16BE: begin
        c.width = W16;
        c.big = 1'b1;
      end
      FMT_S16BE: begin
        c.width = W16;
        c.is_signed = 1'b1;
        c.big = 1'b1;
      end
      FMT_U32LE: begin
        c.width = W32;
      end
      FMT_S32LE: begin
        c.width = W32;
        c.is_signed = 1'b1;
      end
      FMT_U32BE: begin
        c.width = W32;
        c.big = 1'b1;
      end
      FMT_S32BE: begin
        c.width = W32;
        c.is_signed = 1'b1;
        c.big = 1'b1;
      end
      default: begin
        c.legal = 1'b0;
      end
    endcase
    return c;
  endfunction

  // full scale span R = 2^w - 1
  function automatic logic [32:0] fmt_range(input width_t w);
    logic [32:0] r;
    case (w)
      W8:      r = 33'h0_0000_00FF;
      W16:     r = 33'h0_0000_FFFF;
      default: r = 33'h0_FFFF_FFFF;
    endcase
    return r;
  endfunction

  // half scale 2^(w-1), also the sign bit of the format
  function automatic logic [32:0] fmt_half(input width_t w);
    logic [32:0] h;
    case (w)
      W8:      h = 33'h0_0000_0080;
      W16:     h = 33'h0_0000_8000;
      default: h = 33'h0_8000_0000;
    endcase
    return h;
  endfunction

  // byte reversal within the format width
  function automatic logic [31:0] swap_bytes(input logic [31:0] x, input width_t w);
    logic [31:0] y;
    case (w)
      W8:      y = x;
      W16:     y = {16'h0000, x[7:0], x[15:8]};
      default: y = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endcase
    return y;
  endfunction

  // stored word to offset value in [0, R]
  function automatic logic [31:0] read_sample(input logic [31:0] x, input fmt_ctrl_t c);
    logic [32:0] r;
    logic [32:0] h;
    logic [31:0] m;
    r = fmt_range(c.width);
    h = fmt_half(c.width);
    m = x & r[31:0];
    if (c.big) begin
      m = swap_bytes(m, c.width);
    end
    if (c.is_signed) begin
      m = m ^ h[31:0];
    end
    return m;
  endfunction

  // offset value back to stored word
  function automatic logic [31:0] write_sample(input logic [31:0] u, input fmt_ctrl_t c);
    logic [32:0] r;
    logic [32:0] h;
    logic [31:0] m;
    r = fmt_range(c.width);
    h = fmt_half(c.width);
    m = u & r[31:0];
    if (c.is_signed) begin
      m = m ^ h[31:0];
    end
    if (c.big) begin
      m = swap_bytes(m, c.width);
    end
    if (!c.legal) begin
      m = 32'h0000_0000;
    end
    return m;
  endfunction

endpackage

@@ design/pcm_sample_mixer.sv @@
`timescale 1ns / 1ps

// Saturating mixer for two PCM samples in one configured format.
// Input channel: in_valid / in_ready carry a word of dst_sample and
// src_sample, stored as in memory (low bits used for narrow formats).
// Output channel: out_valid / out_ready carry mixed_sample, in the same
// format and byte order, with the bits above the format width zero.
// Format register: cfg_wdata is written when cfg_we is high; change it
// only while the block is empty. Codes 10 to 15 give a result of zero.
// Pipeline: four register stages (unpack, add, clamp, repack into the
// output register), the first of which loads at the accepting edge.
// Throughput: one word per cycle while out_ready is high; each stage
// holds one word and moves on whenever the stage after it is empty or
// moving.
// Reset clears all stage valid bits and sets the format to unsigned 8 bit.
// When the receiver stalls, words pile up stage by stage; the input keeps
// accepting until all four stages are full, and nothing is lost.
module pcm_sample_mixer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] dst_sample,
  input  logic [31:0] src_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] mixed_sample
);
  import pcmmix_pkg::*;

  logic [3:0] fmt_code;
  fmt_ctrl_t  cur_ctrl;

  // stage registers
  logic        v1;
  fmt_ctrl_t   c1;
  logic [31:0] ua;
  logic [31:0] ub;
  logic        v2;
  fmt_ctrl_t   c2;
  logic [32:0] sum;
  logic        v3;
  fmt_ctrl_t   c3;
  logic [31:0] mixv;

  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic rdy4;

  logic [32:0] range2;
  logic [32:0] half2;
  logic        low_clip;
  logic        inc;
  logic [32:0] diff;
  logic [31:0] mixv_next;

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_code <= FMT_U8;
    end else if (cfg_we) begin
      fmt_code <= cfg_wdata;
    end
  end

  assign cur_ctrl = decode_fmt(fmt_code);

  // stall chain, each stage takes a word when it is empty or emptying
  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // stage 1: unpack both samples to offset values
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      c1 <= cur_ctrl;
      ua <= read_sample(dst_sample, cur_ctrl);
      ub <= read_sample(src_sample, cur_ctrl);
    end
  end

  // stage 2: sum of offset values
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      c2  <= c1;
      sum <= {1'b0, ua} + {1'b0, ub};
    end
  end

  // stage 3: remove half scale and clamp to [0, R]
  // signed formats round toward zero, which adds one below midscale
  always_comb begin
    range2   = fmt_range(c2.width);
    half2    = fmt_half(c2.width);
    low_clip = sum < half2;
    inc      = c2.is_signed && (sum <= range2);
    diff     = sum - half2 + {32'h0000_0000, inc};
    if (low_clip) begin
      mixv_next = 32'h0000_0000;
    end else if (diff > range2) begin
      mixv_next = range2[31:0];
    end else begin
      mixv_next = diff[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      c3   <= c2;
      mixv <= mixv_next;
    end
  end

  // stage 4: repack into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      mixed_sample <= write_sample(mixv, c3);
    end
  end

  // checks
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("accepted word missing from first stage");

  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> ({1'b0, mixv} <= fmt_range(c3.width)))
    else $error("clamped value above full scale");

  a_illegal_zero: assert property (@(posedge clk) disable iff (rst)
    (rdy4 && v3 && !c3.legal) |=> (mixed_sample == 32'h0000_0000))
    else $error("undefined format gave nonzero word");

  a_narrow_upper: assert property (@(posedge clk) disable iff (rst)
    (rdy4 && v3 && c3.width == W8) |=> (mixed_sample[31:8] == 24'h000000))
    else $error("8 bit word has upper bits set");

endmodule
